// ===== sv/ostt_pkg.sv =====
`timescale 1ns / 1ps

package ostt_pkg;

    localparam int NUM_SLOTS = 64;
    localparam int TAG_BITS  = 16;

    localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TIME_W    = 32;
    localparam int DELAY_W   = 24;
    localparam int IN_TAG_W  = 16;
    localparam int SLOT_W    = 6;
    localparam int KIND_W    = 2;
    localparam int ENTRY_W   = TIME_W + TAG_BITS;

    localparam logic OP_SET  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_FIRED    = 2'd2
    } t_kind;

    typedef logic [TAG_BITS-1:0] t_tag;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [TIME_W-1:0]   t_time;

    // Keep the low TAG_BITS of a request tag.
    function automatic t_tag keep_tag(input logic [IN_TAG_W-1:0] tag_in);
        logic [31:0] w;
        w = 32'(tag_in);
        return w[TAG_BITS-1:0];
    endfunction

    // Widen or trim a kept tag to the result field.
    function automatic logic [IN_TAG_W-1:0] out_tag(input t_tag tag_in);
        logic [31:0] w;
        w = 32'(tag_in);
        return w[IN_TAG_W-1:0];
    endfunction

endpackage

// ===== sv/ostt_req_if.sv =====
`timescale 1ns / 1ps

interface ostt_req_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic [ostt_pkg::DELAY_W-1:0]      delay_ms;
    logic [ostt_pkg::IN_TAG_W-1:0]     tag;

    modport source (output valid, output opcode, output delay_ms, output tag, input ready);
    modport sink   (input valid, input opcode, input delay_ms, input tag, output ready);
endinterface

// ===== sv/ostt_res_if.sv =====
`timescale 1ns / 1ps

interface ostt_res_if;
    logic                              valid;
    logic                              ready;
    ostt_pkg::t_kind                   kind;
    logic [ostt_pkg::SLOT_W-1:0]       slot;
    logic [ostt_pkg::IN_TAG_W-1:0]     fired_tag;
    logic                              last;

    modport source (output valid, output kind, output slot, output fired_tag, output last,
                    input ready);
    modport sink   (input valid, input kind, input slot, input fired_tag, input last,
                    output ready);
endinterface

// ===== sv/one_shot_timer_table.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                              Handshake
// i_req     in   opcode, delay_ms, tag                valid/ready, request taken on both high
// o_res     out  kind, slot, fired_tag, last          valid/ready, result taken on both high
//
// Set: taken when the hold stage is empty; its result passes from the hold stage to the output
// register, and the next request waits until the hold stage is empty again.
// Tick: the scan reads one slot entry per cycle while not stalled and stays busy until every
// slot is checked; the next request waits for the scan to end and the hold stage to empty.
// A stalled output blocks the input; it stalls the scan only when a second due slot needs
// the hold stage. Reset clears time, armed flags and handshake state, not the slot memory.

module one_shot_timer_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ostt_req_if.sink      i_req,
    ostt_res_if.source    o_res
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    localparam ostt_pkg::t_idx LAST_SLOT = ostt_pkg::IDX_W'(ostt_pkg::NUM_SLOTS - 1);

    // Control state
    t_state                          r_state,      n_state;
    ostt_pkg::t_time                 r_now,        n_now;
    logic [ostt_pkg::NUM_SLOTS-1:0]  r_armed,      n_armed;
    ostt_pkg::t_idx                  r_rd_idx,     n_rd_idx;
    logic                            r_rd_more,    n_rd_more;
    logic                            r_chk_valid,  n_chk_valid;
    ostt_pkg::t_idx                  r_chk_idx,    n_chk_idx;
    logic                            r_hold_valid, n_hold_valid;
    logic                            r_hold_last,  n_hold_last;
    logic                            r_out_valid,  n_out_valid;

    // Payload of the hold stage and the output register
    ostt_pkg::t_kind                 r_hold_kind,  n_hold_kind;
    logic [ostt_pkg::SLOT_W-1:0]     r_hold_slot,  n_hold_slot;
    ostt_pkg::t_tag                  r_hold_tag,   n_hold_tag;
    ostt_pkg::t_kind                 r_out_kind,   n_out_kind;
    logic [ostt_pkg::SLOT_W-1:0]     r_out_slot,   n_out_slot;
    logic [ostt_pkg::IN_TAG_W-1:0]   r_out_tag,    n_out_tag;
    logic                            r_out_last,   n_out_last;

    // Datapath
    logic                            req_accept;
    logic [ostt_pkg::NUM_SLOTS-1:0]  free_vec;
    logic [ostt_pkg::NUM_SLOTS-1:0]  free_low;
    ostt_pkg::t_idx                  free_idx;
    logic                            table_full;
    ostt_pkg::t_tag                  req_tag;
    logic                            ram_wr_en;
    logic [ostt_pkg::ENTRY_W-1:0]    ram_wr_data;
    logic                            ram_rd_en;
    logic [ostt_pkg::ENTRY_W-1:0]    ram_rd_data;
    ostt_pkg::t_time                 rd_deadline;
    ostt_pkg::t_tag                  rd_tag;
    ostt_pkg::t_time                 age;
    logic                            fire;
    logic                            out_free;
    logic                            move;
    logic                            stall;

    assign req_accept = i_req.valid && i_req.ready;
    assign req_tag    = ostt_pkg::keep_tag(i_req.tag);

    // Lowest free slot: isolate the lowest set bit of the free vector, then encode it.
    always_comb begin
        free_vec = ~r_armed;
        free_low = free_vec & (~free_vec + ostt_pkg::NUM_SLOTS'(1));
        free_idx = '0;
        for (int i = 0; i < ostt_pkg::NUM_SLOTS; i++) begin
            if (free_low[i]) begin
                free_idx = free_idx | ostt_pkg::IDX_W'(i);
            end
        end
        table_full = ~|free_vec;
    end

    // Slot memory: {tag, deadline} per slot.
    assign ram_wr_en   = req_accept && (i_req.opcode == ostt_pkg::OP_SET) && !table_full;
    assign ram_wr_data = {req_tag, r_now + ostt_pkg::TIME_W'(i_req.delay_ms)};

    ostt_ram #(
        .WIDTH (ostt_pkg::ENTRY_W),
        .DEPTH (ostt_pkg::NUM_SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (free_idx),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (ram_rd_data)
    );

    assign rd_deadline = ram_rd_data[ostt_pkg::TIME_W-1:0];
    assign rd_tag      = ram_rd_data[ostt_pkg::ENTRY_W-1:ostt_pkg::TIME_W];

    // Wrap-safe due test: elapsed time since the deadline lies in the lower half range.
    assign age  = r_now - rd_deadline;
    assign fire = (r_state == S_SCAN) && r_chk_valid && r_armed[r_chk_idx]
                  && !age[ostt_pkg::TIME_W-1];

    // The hold stage keeps the latest fired slot until we know whether another follows.
    // Move it to the output once its last flag is settled, or when a new fire displaces it.
    assign out_free  = !r_out_valid || o_res.ready;
    assign move      = r_hold_valid && out_free && (r_hold_last || fire);
    assign stall     = fire && r_hold_valid && !move;
    assign ram_rd_en = (r_state == S_SCAN) && !stall && r_rd_more;

    assign i_req.ready = (r_state == S_IDLE) && !r_hold_valid;

    always_comb begin
        n_state      = r_state;
        n_now        = r_now;
        n_armed      = r_armed;
        n_rd_idx     = r_rd_idx;
        n_rd_more    = r_rd_more;
        n_chk_valid  = r_chk_valid;
        n_chk_idx    = r_chk_idx;
        n_hold_valid = r_hold_valid;
        n_hold_last  = r_hold_last;
        n_hold_kind  = r_hold_kind;
        n_hold_slot  = r_hold_slot;
        n_hold_tag   = r_hold_tag;
        n_out_valid  = r_out_valid;
        n_out_kind   = r_out_kind;
        n_out_slot   = r_out_slot;
        n_out_tag    = r_out_tag;
        n_out_last   = r_out_last;

        unique case (r_state)
            S_IDLE: begin
                if (req_accept) begin
                    if (i_req.opcode == ostt_pkg::OP_SET) begin
                        // Claim a slot or report full; the result is complete at once.
                        n_hold_valid = 1'b1;
                        n_hold_last  = 1'b1;
                        n_hold_tag   = req_tag;
                        if (table_full) begin
                            n_hold_kind = ostt_pkg::KIND_FULL;
                            n_hold_slot = '0;
                        end else begin
                            n_hold_kind       = ostt_pkg::KIND_ACCEPTED;
                            n_hold_slot       = ostt_pkg::SLOT_W'(free_idx);
                            n_armed[free_idx] = 1'b1;
                        end
                    end else begin
                        // Advance time, then sweep every slot.
                        n_now       = r_now + ostt_pkg::TIME_W'(1);
                        n_state     = S_SCAN;
                        n_rd_idx    = '0;
                        n_rd_more   = 1'b1;
                        n_chk_valid = 1'b0;
                    end
                end
            end
            S_SCAN: begin
                if (!stall) begin
                    n_chk_valid = r_rd_more;
                    n_chk_idx   = r_rd_idx;
                    if (r_rd_more) begin
                        if (r_rd_idx == LAST_SLOT) begin
                            n_rd_more = 1'b0;
                        end else begin
                            n_rd_idx = r_rd_idx + ostt_pkg::IDX_W'(1);
                        end
                    end
                    if (!r_rd_more && !r_chk_valid) begin
                        // Sweep done: the held result, if any, ends the run.
                        n_state     = S_IDLE;
                        n_hold_last = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (move) begin
            n_out_valid = 1'b1;
            n_out_kind  = r_hold_kind;
            n_out_slot  = r_hold_slot;
            n_out_tag   = ostt_pkg::out_tag(r_hold_tag);
            n_out_last  = r_hold_last;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        if (fire && !stall) begin
            // Capture the due slot and disarm it.
            n_hold_valid       = 1'b1;
            n_hold_last        = 1'b0;
            n_hold_kind        = ostt_pkg::KIND_FIRED;
            n_hold_slot        = ostt_pkg::SLOT_W'(r_chk_idx);
            n_hold_tag         = rd_tag;
            n_armed[r_chk_idx] = 1'b0;
        end else if (move) begin
            n_hold_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_now        <= '0;
            r_armed      <= '0;
            r_rd_idx     <= '0;
            r_rd_more    <= 1'b0;
            r_chk_valid  <= 1'b0;
            r_chk_idx    <= '0;
            r_hold_valid <= 1'b0;
            r_hold_last  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_now        <= n_now;
            r_armed      <= n_armed;
            r_rd_idx     <= n_rd_idx;
            r_rd_more    <= n_rd_more;
            r_chk_valid  <= n_chk_valid;
            r_chk_idx    <= n_chk_idx;
            r_hold_valid <= n_hold_valid;
            r_hold_last  <= n_hold_last;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_kind <= n_hold_kind;
        r_hold_slot <= n_hold_slot;
        r_hold_tag  <= n_hold_tag;
        r_out_kind  <= n_out_kind;
        r_out_slot  <= n_out_slot;
        r_out_tag   <= n_out_tag;
        r_out_last  <= n_out_last;
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_out_kind;
    assign o_res.slot      = r_out_slot;
    assign o_res.fired_tag = r_out_tag;
    assign o_res.last      = r_out_last;

endmodule

// ===== sv/ostt_ram.sv =====
`timescale 1ns / 1ps

module ostt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                         i_wr_data,
    input  logic                                     i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/ostt_checker.sv =====
`timescale 1ns / 1ps

module ostt_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_req_valid,
    input logic                              i_req_ready,
    input logic                              i_res_valid,
    input logic                              i_res_ready,
    input ostt_pkg::t_kind                   i_res_kind,
    input logic [ostt_pkg::SLOT_W-1:0]       i_res_slot,
    input logic [ostt_pkg::IN_TAG_W-1:0]     i_res_fired_tag,
    input logic                              i_res_last
);

    // One request at a time: a taken request deasserts ready in the cycle after it is taken.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken in the cycle after another");

    // A full table reports slot zero and ends its run.
    a_full_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res_kind == ostt_pkg::KIND_FULL)) |-> ((i_res_slot == '0) && i_res_last))
        else $error("table full result with nonzero slot or without last");

    // A set acknowledge is always the only result of its request.
    a_accept_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && (i_res_kind == ostt_pkg::KIND_ACCEPTED)) |-> i_res_last)
        else $error("set acknowledge without last");

    // A stalled result holds.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_kind)
            && $stable(i_res_slot) && $stable(i_res_fired_tag) && $stable(i_res_last)))
        else $error("stalled result changed");

endmodule

bind one_shot_timer_table ostt_checker u_ostt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_res_valid     (o_res.valid),
    .i_res_ready     (o_res.ready),
    .i_res_kind      (o_res.kind),
    .i_res_slot      (o_res.slot),
    .i_res_fired_tag (o_res.fired_tag),
    .i_res_last      (o_res.last)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import ostt_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 10;
    // A tick scans every slot; the receiver hold-off below is the longest stretch
    // with nothing accepted.
    localparam int HOLD_AT      = 55;
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCHDOG     = 4000;
    localparam int TAIL_ITEMS   = 30;
    localparam int DRAIN_CYCLES = 4 * NUM_SLOTS;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic                opcode;
        logic [DELAY_W-1:0]  delay_ms;
        logic [IN_TAG_W-1:0] tag;
    } timer_req_t;

    typedef struct packed {
        t_kind               kind;
        logic [SLOT_W-1:0]   slot;
        logic [IN_TAG_W-1:0] fired_tag;
        logic                last;
    } timer_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ostt_req_if req_ch();
    ostt_res_if res_ch();

    one_shot_timer_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Requests still to be offered, and results the table is expected to emit.
    timer_req_t pending_reqs[$];
    timer_res_t expected_results[$];

    // Shadow of the timer table: time counter, armed flags, deadlines and tags.
    t_time timer_now;
    logic  timer_armed [NUM_SLOTS];
    t_time timer_deadline [NUM_SLOTS];
    t_tag  timer_tag [NUM_SLOTS];

    int   fail_count  = 0;
    int   reqs_taken  = 0;
    int   idle_cycles = 0;
    logic req_taken   = 1'b0;
    int   send_gap    = 0;
    int   recv_gap    = 0;
    int   hold_left   = 0;
    logic hold_done   = 1'b0;

    // Work out the results of one accepted request and advance the shadow table.
    task automatic predict_timer_request(input timer_req_t r);
        timer_res_t res;
        t_tag       kept;
        t_time      age;
        int         free_slot;
        int         fired;
        kept      = r.tag[TAG_BITS-1:0];
        free_slot = -1;
        fired     = 0;
        if (r.opcode == OP_SET) begin
            // Claim the lowest free slot, or report the table full.
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (free_slot < 0 && !timer_armed[i]) begin
                    free_slot = i;
                end
            end
            res.fired_tag = IN_TAG_W'(kept);
            res.last      = 1'b1;
            if (free_slot < 0) begin
                res.kind = KIND_FULL;
                res.slot = '0;
            end else begin
                timer_armed[free_slot]    = 1'b1;
                timer_deadline[free_slot] = timer_now + t_time'(r.delay_ms);
                timer_tag[free_slot]      = kept;
                res.kind = KIND_ACCEPTED;
                res.slot = SLOT_W'(free_slot);
            end
            expected_results.push_back(res);
        end else begin
            // Advance time first, then fire every armed slot whose deadline is reached,
            // judged by the sign of the modular age.
            timer_now = timer_now + 1;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                age = timer_now - timer_deadline[i];
                if (timer_armed[i] && !age[TIME_W-1]) begin
                    res.kind      = KIND_FIRED;
                    res.slot      = SLOT_W'(i);
                    res.fired_tag = IN_TAG_W'(timer_tag[i]);
                    res.last      = 1'b0;
                    expected_results.push_back(res);
                    timer_armed[i] = 1'b0;
                    fired++;
                end
            end
            // Mark the final result of this tick.
            if (fired > 0) begin
                res      = expected_results.pop_back();
                res.last = 1'b1;
                expected_results.push_back(res);
            end
        end
    endtask

    task automatic queue_set(input logic [DELAY_W-1:0] delay, input logic [IN_TAG_W-1:0] tag);
        timer_req_t r;
        r.opcode   = OP_SET;
        r.delay_ms = delay;
        r.tag      = tag;
        pending_reqs.push_back(r);
    endtask

    // Ticks carry random junk in the unused fields; the table must ignore it.
    task automatic queue_tick();
        timer_req_t r;
        r.opcode   = OP_TICK;
        r.delay_ms = DELAY_W'($urandom);
        r.tag      = IN_TAG_W'($urandom);
        pending_reqs.push_back(r);
    endtask

    // Short delays keep timers firing within the run; a few full-width delays
    // exercise every delay bit and park slots far in the future.
    task automatic queue_random_set();
        logic [DELAY_W-1:0] delay;
        if ($urandom_range(0, 15) == 0) begin
            delay = DELAY_W'($urandom);
        end else begin
            delay = DELAY_W'($urandom_range(0, 12));
        end
        queue_set(delay, IN_TAG_W'($urandom));
    endtask

    // Monitor: take requests into the predictor and check results, both on the rising edge.
    always @(posedge i_clk) begin
        timer_res_t exp_res;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            req_taken <= req_ch.valid && req_ch.ready;
            if (req_ch.valid && req_ch.ready) begin
                predict_timer_request('{opcode: req_ch.opcode, delay_ms: req_ch.delay_ms,
                                        tag: req_ch.tag});
                reqs_taken <= reqs_taken + 1;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("ERROR %0t: unexpected result kind=%0d slot=%0d tag=%h last=%b",
                                 $realtime, res_ch.kind, res_ch.slot, res_ch.fired_tag,
                                 res_ch.last);
                    end
                end else begin
                    exp_res = expected_results.pop_front();
                    if (res_ch.kind !== exp_res.kind || res_ch.slot !== exp_res.slot ||
                        res_ch.fired_tag !== exp_res.fired_tag ||
                        res_ch.last !== exp_res.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS) begin
                            $display("ERROR %0t: expected kind=%0d slot=%0d tag=%h last=%b",
                                     $realtime, exp_res.kind, exp_res.slot,
                                     exp_res.fired_tag, exp_res.last);
                            $display("ERROR %0t:   actual kind=%0d slot=%0d tag=%h last=%b",
                                     $realtime, res_ch.kind, res_ch.slot, res_ch.fired_tag,
                                     res_ch.last);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: give up after a long run of cycles with nothing accepted on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG) begin
            $display("ERROR %0t: no progress for %0d cycles", $realtime, WATCHDOG);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hold off the receiver once, long enough for queued sets to back up into the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && reqs_taken >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // Request driver: advance to the next pending request once the current one is taken,
    // with random idle bursts between requests until the tail of the run.
    always @(negedge i_clk) begin
        timer_req_t nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (send_gap > 0) begin
                req_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (pending_reqs.size() > 0) begin
                nxt = pending_reqs.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.opcode   <= nxt.opcode;
                req_ch.delay_ms <= nxt.delay_ms;
                req_ch.tag      <= nxt.tag;
                // Keep offering without gaps while the receiver is held off.
                if (pending_reqs.size() > TAIL_ITEMS && hold_left == 0 &&
                    $urandom_range(0, 4) == 0) begin
                    send_gap <= $urandom_range(1, 6);
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result ready: drop it during the long hold-off and in random short bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
        end else if (recv_gap > 0) begin
            res_ch.ready <= 1'b0;
            recv_gap     <= recv_gap - 1;
        end else begin
            res_ch.ready <= 1'b1;
            if (pending_reqs.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
                recv_gap <= $urandom_range(1, 6);
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.opcode   = OP_SET;
        req_ch.delay_ms = '0;
        req_ch.tag      = '0;
        res_ch.ready    = 1'b0;
        timer_now       = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            timer_armed[i]    = 1'b0;
            timer_deadline[i] = '0;
            timer_tag[i]      = '0;
        end

        // Directed: zero delay fires on the next tick, max delay never fires, lowest free
        // slot is reused, a tick with nothing due, several slots sharing one deadline.
        queue_set('0, '0);
        queue_set('1, '1);
        queue_set(24'd1, 16'h5A5A);
        queue_set(24'd2, 16'hA5A5);
        queue_tick();
        queue_set('0, 16'h0001);
        queue_tick();
        queue_tick();
        queue_set(24'd3, 16'h1111);
        queue_set(24'd3, 16'h2222);
        queue_set(24'd3, 16'h4444);
        queue_tick();
        queue_tick();
        queue_tick();
        queue_set(24'h800000, 16'h8000);
        queue_set(24'h7FFFFF, 16'h7FFF);
        queue_tick();
        queue_tick();

        // Random mix of sets and ticks.
        for (int n = 0; n < 10; n++) begin
            if ($urandom_range(0, 9) < 4) begin
                queue_random_set();
            end else begin
                queue_tick();
            end
        end

        // Fill the table past full with short timers, then tick until they all fire.
        for (int n = 0; n < NUM_SLOTS + 6; n++) begin
            queue_set(DELAY_W'($urandom_range(0, 6)), IN_TAG_W'($urandom));
        end
        for (int n = 0; n < 10; n++) begin
            queue_tick();
        end

        for (int n = 0; n < 15; n++) begin
            if ($urandom_range(0, 1) == 0) begin
                queue_random_set();
            end else begin
                queue_tick();
            end
        end
        queue_tick();

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_reqs.size() == 0);
        @(posedge i_clk);
        while (req_ch.valid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/ostt_pkg.sv
sv/ostt_req_if.sv
sv/ostt_res_if.sv
sv/ostt_ram.sv
sv/one_shot_timer_table.sv
sv/ostt_checker.sv
tb/testbench.sv
